@@ hdl/esdp_pkg.sv @@
// shared types and constants of the elementary stream descriptor parser
package esdp_pkg;

  // descriptor tags
  localparam logic [7:0] TagEsDesc      = 8'h03;
  localparam logic [7:0] TagDecConfig   = 8'h04;
  localparam logic [7:0] TagDecSpecific = 8'h05;
  localparam logic [7:0] TagSlConfig    = 8'h06;

  // length field: 7-bit groups, bit 7 flags another group
  localparam int unsigned MaxLenBytes = 4;
  localparam int unsigned LenWidth    = 28;
  localparam int unsigned CntWidth    = 3;
  localparam int unsigned BaseWidth   = 48;
  localparam int unsigned OffWidth    = 32;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_e;

  typedef enum logic [16:0] {
    PH_TAG1  = 17'b0_0000_0000_0000_0001,
    PH_LEN1  = 17'b0_0000_0000_0000_0010,
    PH_ID    = 17'b0_0000_0000_0000_0100,
    PH_PRIO  = 17'b0_0000_0000_0000_1000,
    PH_TAG2  = 17'b0_0000_0000_0001_0000,
    PH_LEN2  = 17'b0_0000_0000_0010_0000,
    PH_OBJ   = 17'b0_0000_0000_0100_0000,
    PH_STYPE = 17'b0_0000_0000_1000_0000,
    PH_BUF   = 17'b0_0000_0001_0000_0000,
    PH_MAXR  = 17'b0_0000_0010_0000_0000,
    PH_AVGR  = 17'b0_0000_0100_0000_0000,
    PH_TAG3  = 17'b0_0000_1000_0000_0000,
    PH_LEN3  = 17'b0_0001_0000_0000_0000,
    PH_UNK   = 17'b0_0010_0000_0000_0000,
    PH_TAG4  = 17'b0_0100_0000_0000_0000,
    PH_LEN4  = 17'b0_1000_0000_0000_0000,
    PH_SKIP  = 17'b1_0000_0000_0000_0000
  } phase_e;

  typedef struct packed {
    status_e                status;
    logic [15:0]            es_id;
    logic [7:0]             stream_priority;
    logic [7:0]             object_type;
    logic [7:0]             stream_kind;
    logic [23:0]            buffer_size;
    logic [31:0]            max_bitrate;
    logic [31:0]            avg_bitrate;
    logic [BaseWidth-1:0]   extra_start;
    logic [LenWidth-1:0]    extra_length;
  } result_t;

endpackage

@@ hdl/es_descriptor_parser.sv @@
// Elementary stream descriptor parser, top level.
// Input channel: one payload byte per transfer (data_byte_i, last_byte_i) on
// in_valid_i / in_stall_o; last_byte_i marks the final byte of the box.
// Output channel: one result per decision on out_valid_o / out_stall_i:
// ok with the decoder specific data position and length, not found, or
// truncated when the box ends early. Bytes after a result are skipped.
// Configuration: cfg_we_i writes cfg_wdata_i into payload_base, the stream
// position of the first payload byte; write it only while the block is idle.
// Path: a result passes the input register, then the result register, on its
// way from the transfer of the byte that decides it to the output.
// Throughput: one byte per cycle; the parser state update is a single pass
// of short logic between the input register and the result register.
// When the receiver stalls with a result pending, bytes that produce no
// result still flow; a byte that would produce one waits in the input
// register and in_stall_o rises.
// Reset: the parser returns to the first tag, all fields and the byte offset
// clear, payload_base goes to zero and both channels are empty.
module es_descriptor_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     data_byte_i,
  input  logic                           last_byte_i,
  input  logic                           cfg_we_i,
  input  logic [esdp_pkg::BaseWidth-1:0] cfg_wdata_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     status_o,
  output logic [15:0]                    es_id_o,
  output logic [7:0]                     stream_priority_o,
  output logic [7:0]                     object_type_o,
  output logic [7:0]                     stream_kind_o,
  output logic [23:0]                    buffer_size_o,
  output logic [31:0]                    max_bitrate_o,
  output logic [31:0]                    avg_bitrate_o,
  output logic [esdp_pkg::BaseWidth-1:0] extra_start_o,
  output logic [esdp_pkg::LenWidth-1:0]  extra_length_o
);

  logic              byte_valid;
  logic [7:0]        byte_data;
  logic              byte_last;
  logic              step;
  logic              res_valid;
  logic              out_ready;
  esdp_pkg::result_t res;
  esdp_pkg::result_t res_out;

  // a byte is consumed unless its result cannot enter the output register
  assign step = byte_valid && (!res_valid || out_ready);

  esdp_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .take_i      (step),
    .valid_o     (byte_valid),
    .data_o      (byte_data),
    .last_o      (byte_last)
  );

  esdp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .valid_i     (byte_valid),
    .step_i      (step),
    .data_i      (byte_data),
    .last_i      (byte_last),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  esdp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && res_valid),
    .res_i       (res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  // result fields to ports
  assign status_o          = res_out.status;
  assign es_id_o           = res_out.es_id;
  assign stream_priority_o = res_out.stream_priority;
  assign object_type_o     = res_out.object_type;
  assign stream_kind_o     = res_out.stream_kind;
  assign buffer_size_o     = res_out.buffer_size;
  assign max_bitrate_o     = res_out.max_bitrate;
  assign avg_bitrate_o     = res_out.avg_bitrate;
  assign extra_start_o     = res_out.extra_start;
  assign extra_length_o    = res_out.extra_length;

endmodule

@@ hdl/esdp_in_reg.sv @@
// input register stage for descriptor bytes
module esdp_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] data_o,
  output logic       last_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       last_q;
  logic       accept;

  // hold off the sender only while a byte sits here and is not consumed
  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (!valid_q || take_i) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, loaded on each input transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign last_o  = last_q;

endmodule

@@ hdl/esdp_parser.sv @@
// parser state, field registers and result formation for one byte per cycle while step_i is high
module esdp_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [esdp_pkg::BaseWidth-1:0] cfg_wdata_i,
  input  logic                           valid_i,
  input  logic                           step_i,
  input  logic [7:0]                     data_i,
  input  logic                           last_i,
  output logic                           res_valid_o,
  output esdp_pkg::result_t              res_o
);

  esdp_pkg::phase_e                    phase_q, phase_d;
  logic [esdp_pkg::CntWidth-1:0]       cnt_q, cnt_d;
  logic [esdp_pkg::LenWidth-1:0]       len_q, len_d;
  logic [7:0]                          tag_q, tag_d;
  logic [esdp_pkg::OffWidth-1:0]       off_q, off_d;
  logic [15:0]                         id_q, id_d;
  logic [7:0]                          prio_q, prio_d;
  logic [7:0]                          obj_q, obj_d;
  logic [7:0]                          stype_q, stype_d;
  logic [23:0]                         buf_q, buf_d;
  logic [31:0]                         maxr_q, maxr_d;
  logic [31:0]                         avgr_q, avgr_d;
  logic [esdp_pkg::BaseWidth-1:0]      base_q;

  logic [esdp_pkg::CntWidth-1:0]       cnt_inc;
  logic [esdp_pkg::LenWidth-1:0]       len_nx;
  logic                                len_done;
  logic                                emit;
  logic                                with_extra;
  esdp_pkg::status_e                   status;

  // shared helpers for length groups and multi-byte fields
  assign cnt_inc  = cnt_q + 3'd1;
  assign len_nx   = {len_q[esdp_pkg::LenWidth-8:0], data_i[6:0]};
  assign len_done = !data_i[7] || (cnt_inc >= esdp_pkg::CntWidth'(esdp_pkg::MaxLenBytes));

  // next state for the byte in the input register
  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    len_d      = len_q;
    tag_d      = tag_q;
    off_d      = off_q + 32'd1;
    id_d       = id_q;
    prio_d     = prio_q;
    obj_d      = obj_q;
    stype_d    = stype_q;
    buf_d      = buf_q;
    maxr_d     = maxr_q;
    avgr_d     = avgr_q;
    emit       = 1'b0;
    with_extra = 1'b0;
    status     = esdp_pkg::ST_NOT_FOUND;

    unique case (phase_q) inside
      esdp_pkg::PH_TAG1, esdp_pkg::PH_TAG2, esdp_pkg::PH_TAG3, esdp_pkg::PH_TAG4: begin
        tag_d = data_i;
        len_d = '0;
        cnt_d = '0;
        unique case (phase_q)
          esdp_pkg::PH_TAG1: phase_d = esdp_pkg::PH_LEN1;
          esdp_pkg::PH_TAG2: phase_d = esdp_pkg::PH_LEN2;
          esdp_pkg::PH_TAG3: phase_d = esdp_pkg::PH_LEN3;
          default:           phase_d = esdp_pkg::PH_LEN4;
        endcase
      end
      esdp_pkg::PH_LEN1, esdp_pkg::PH_LEN2, esdp_pkg::PH_LEN3, esdp_pkg::PH_LEN4: begin
        len_d = len_nx;
        cnt_d = len_done ? '0 : cnt_inc;
        if (len_done) begin
          unique case (phase_q)
            esdp_pkg::PH_LEN1: phase_d = esdp_pkg::PH_ID;
            esdp_pkg::PH_LEN2: begin
              if (tag_q == esdp_pkg::TagDecConfig) begin
                phase_d = esdp_pkg::PH_OBJ;
              end else begin
                emit = 1'b1;
              end
            end
            esdp_pkg::PH_LEN3: begin
              if (tag_q == esdp_pkg::TagSlConfig) begin
                phase_d = esdp_pkg::PH_UNK;
              end else begin
                emit       = 1'b1;
                with_extra = (tag_q == esdp_pkg::TagDecSpecific);
              end
            end
            default: begin
              emit       = 1'b1;
              with_extra = (tag_q == esdp_pkg::TagDecSpecific);
            end
          endcase
        end
      end
      esdp_pkg::PH_ID: begin
        id_d  = {id_q[7:0], data_i};
        cnt_d = (cnt_inc >= 3'd2) ? '0 : cnt_inc;
        if (cnt_inc >= 3'd2) begin
          phase_d = (tag_q == esdp_pkg::TagEsDesc) ? esdp_pkg::PH_PRIO : esdp_pkg::PH_TAG2;
        end
      end
      esdp_pkg::PH_PRIO: begin
        prio_d  = data_i;
        phase_d = esdp_pkg::PH_TAG2;
      end
      esdp_pkg::PH_OBJ: begin
        obj_d   = data_i;
        phase_d = esdp_pkg::PH_STYPE;
      end
      esdp_pkg::PH_STYPE: begin
        stype_d = data_i;
        phase_d = esdp_pkg::PH_BUF;
      end
      esdp_pkg::PH_BUF: begin
        buf_d = {buf_q[15:0], data_i};
        cnt_d = (cnt_inc >= 3'd3) ? '0 : cnt_inc;
        if (cnt_inc >= 3'd3) phase_d = esdp_pkg::PH_MAXR;
      end
      esdp_pkg::PH_MAXR: begin
        maxr_d = {maxr_q[23:0], data_i};
        cnt_d  = (cnt_inc >= 3'd4) ? '0 : cnt_inc;
        if (cnt_inc >= 3'd4) phase_d = esdp_pkg::PH_AVGR;
      end
      esdp_pkg::PH_AVGR: begin
        avgr_d = {avgr_q[23:0], data_i};
        cnt_d  = (cnt_inc >= 3'd4) ? '0 : cnt_inc;
        if (cnt_inc >= 3'd4) phase_d = esdp_pkg::PH_TAG3;
      end
      esdp_pkg::PH_UNK: phase_d = esdp_pkg::PH_TAG4;
      default: ;
    endcase

    if (emit) begin
      phase_d = esdp_pkg::PH_SKIP;
      status  = with_extra ? esdp_pkg::ST_OK : esdp_pkg::ST_NOT_FOUND;
    end

    // box ends before a decision: report truncation
    if (last_i && (phase_d != esdp_pkg::PH_SKIP)) begin
      emit       = 1'b1;
      with_extra = 1'b0;
      status     = esdp_pkg::ST_TRUNCATED;
    end
  end

  // result fields from the updated registers
  always_comb begin
    res_o.status          = status;
    res_o.es_id           = id_d;
    res_o.stream_priority = prio_d;
    res_o.object_type     = obj_d;
    res_o.stream_kind     = stype_d;
    res_o.buffer_size     = buf_d;
    res_o.max_bitrate     = maxr_d;
    res_o.avg_bitrate     = avgr_d;
    res_o.extra_start     = with_extra ?
                            (base_q + {{(esdp_pkg::BaseWidth-esdp_pkg::OffWidth){1'b0}}, off_d})
                            : '0;
    res_o.extra_length    = with_extra ? len_d : '0;
  end

  assign res_valid_o = valid_i && emit;

  // parser state; the last byte of a box restarts everything
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= esdp_pkg::PH_TAG1;
      cnt_q   <= '0;
      len_q   <= '0;
      tag_q   <= '0;
      off_q   <= '0;
      id_q    <= '0;
      prio_q  <= '0;
      obj_q   <= '0;
      stype_q <= '0;
      buf_q   <= '0;
      maxr_q  <= '0;
      avgr_q  <= '0;
    end else if (step_i) begin
      if (last_i) begin
        phase_q <= esdp_pkg::PH_TAG1;
        cnt_q   <= '0;
        len_q   <= '0;
        tag_q   <= '0;
        off_q   <= '0;
        id_q    <= '0;
        prio_q  <= '0;
        obj_q   <= '0;
        stype_q <= '0;
        buf_q   <= '0;
        maxr_q  <= '0;
        avgr_q  <= '0;
      end else begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        len_q   <= len_d;
        tag_q   <= tag_d;
        off_q   <= off_d;
        id_q    <= id_d;
        prio_q  <= prio_d;
        obj_q   <= obj_d;
        stype_q <= stype_d;
        buf_q   <= buf_d;
        maxr_q  <= maxr_d;
        avgr_q  <= avgr_d;
      end
    end
  end

  // payload base register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  // a box end always returns to the first tag with the offset cleared
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> phase_q == esdp_pkg::PH_TAG1 && off_q == '0)
    else $error("parser did not restart after last byte");

  // ok only comes out of the third or fourth descriptor length
  a_ok_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status == esdp_pkg::ST_OK |->
      phase_q == esdp_pkg::PH_LEN3 || phase_q == esdp_pkg::PH_LEN4)
    else $error("ok result outside a length phase");

  // skipped bytes never produce a result
  a_skip_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == esdp_pkg::PH_SKIP |-> !res_valid_o)
    else $error("result while skipping");

  // failed results carry no decoder specific position
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status != esdp_pkg::ST_OK |->
      res_o.extra_start == '0 && res_o.extra_length == '0)
    else $error("extra fields set on a failed result");

endmodule

@@ hdl/esdp_out_reg.sv @@
// result register toward the receiver
module esdp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  esdp_pkg::result_t res_i,
  output logic              ready_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output esdp_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  esdp_pkg::result_t res_q;

  // free when empty or when the held result leaves this cycle
  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

@@ verif/tb_es_descriptor_parser.sv @@
// self-checking testbench of the elementary stream descriptor parser
`timescale 1ns / 1ps

module tb_es_descriptor_parser;

  // directed stimulus row; status, id, priority and object type are typed in where known
  typedef struct packed {
    logic [7:0]        b;
    logic              lst;
    logic              typed;
    esdp_pkg::status_e st;
    logic [15:0]       id;
    logic [7:0]        prio;
    logic [7:0]        obj;
  } dir_row_t;

  localparam int NumDirected = 22;
  localparam int NumPhases   = 6;
  localparam int PhaseBytes  = 205;
  localparam int DrainCycles = 4;

  localparam dir_row_t DirectedRows [NumDirected] = '{
    // box of one byte, all ones, ends at once
    '{8'hFF, 1'b1, 1'b1, esdp_pkg::ST_TRUNCATED, 16'h0000, 8'h00, 8'h00},
    // box of one byte, all zeros
    '{8'h00, 1'b1, 1'b1, esdp_pkg::ST_TRUNCATED, 16'h0000, 8'h00, 8'h00},
    // tag 3 with an overlong length, priority, then a wrong second tag
    '{8'h03, 1'b0, 1'b0, esdp_pkg::ST_OK,        16'h0000, 8'h00, 8'h00},
    '{8'h80, 1'b0, 1'b0, esdp_pkg::ST_OK,        16'h0000, 8'h00, 8'h00},
    '{8'h80, 1'b0, 1'b0, esdp_pkg::ST_OK,        16'h0000, 8'h00, 8'h00},
    '{8'h80, 1'b0, 1'b0, esdp_pkg::ST_OK,        16'h0000, 8'h00, 8'h00},
    '{8'hFF, 1'b0, 1'b0, esdp_pkg::ST_OK,        16'h0000, 8'h00, 8'h00},
    '{8'h12, 1'b0, 1'b0, esdp_pkg::ST_OK,        16'h0000, 8'h00, 8'h00},
    '{8'h34, 1'b0, 1'b0, esdp_pkg::ST_OK,        16'h0000, 8'h00, 8'h00},
    '{8'hFF, 1'b0, 1'b0, esdp_pkg::ST_OK,        16'h0000, 8'h00, 8'h00},
    '{8'h07, 1'b0, 1'b0, esdp_pkg::ST_OK,        16'h0000, 8'h00, 8'h00},
    '{8'h00, 1'b0, 1'b1, esdp_pkg::ST_NOT_FOUND, 16'h1234, 8'hFF, 8'h00},
    // skipped bytes up to the end of the box
    '{8'hAA, 1'b0, 1'b0, esdp_pkg::ST_OK,        16'h0000, 8'h00, 8'h00},
    '{8'h55, 1'b1, 1'b0, esdp_pkg::ST_OK,        16'h0000, 8'h00, 8'h00},
    // tag other than 3 (no priority), tag 4 with two length groups, cut at object type
    '{8'h00, 1'b0, 1'b0, esdp_pkg::ST_OK,        16'h0000, 8'h00, 8'h00},
    '{8'h00, 1'b0, 1'b0, esdp_pkg::ST_OK,        16'h0000, 8'h00, 8'h00},
    '{8'hFF, 1'b0, 1'b0, esdp_pkg::ST_OK,        16'h0000, 8'h00, 8'h00},
    '{8'hFF, 1'b0, 1'b0, esdp_pkg::ST_OK,        16'h0000, 8'h00, 8'h00},
    '{8'h04, 1'b0, 1'b0, esdp_pkg::ST_OK,        16'h0000, 8'h00, 8'h00},
    '{8'h81, 1'b0, 1'b0, esdp_pkg::ST_OK,        16'h0000, 8'h00, 8'h00},
    '{8'h00, 1'b0, 1'b0, esdp_pkg::ST_OK,        16'h0000, 8'h00, 8'h00},
    '{8'h7F, 1'b1, 1'b1, esdp_pkg::ST_TRUNCATED, 16'hFFFF, 8'h00, 8'h7F}
  };

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_stall_o;
  logic [7:0]                      data_byte_i = '0;
  logic                            last_byte_i = 1'b0;
  logic                            cfg_we_i    = 1'b0;
  logic [esdp_pkg::BaseWidth-1:0]  cfg_wdata_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic [1:0]                      status_o;
  logic [15:0]                     es_id_o;
  logic [7:0]                      stream_priority_o;
  logic [7:0]                      object_type_o;
  logic [7:0]                      stream_kind_o;
  logic [23:0]                     buffer_size_o;
  logic [31:0]                     max_bitrate_o;
  logic [31:0]                     avg_bitrate_o;
  logic [esdp_pkg::BaseWidth-1:0]  extra_start_o;
  logic [esdp_pkg::LenWidth-1:0]   extra_length_o;

  // idling percentages of the current phase
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned n_errors  = 0;

  // descriptor results still to come out of the block
  esdp_pkg::result_t pending_results[$];
  logic [7:0] box_bytes[$];

  // parser state mirrored by the testbench
  logic [esdp_pkg::BaseWidth-1:0] base_q;
  esdp_pkg::phase_e               parse_ph;
  logic [esdp_pkg::CntWidth-1:0]  field_cnt;
  logic [esdp_pkg::LenWidth-1:0]  len_acc;
  logic [7:0]                     tag_q;
  logic [esdp_pkg::OffWidth-1:0]  byte_pos;
  logic [15:0]                    id_q;
  logic [7:0]                     prio_q;
  logic [7:0]                     obj_q;
  logic [7:0]                     kind_q;
  logic [23:0]                    buf_q;
  logic [31:0]                    maxr_q;
  logic [31:0]                    avgr_q;

  es_descriptor_parser u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .data_byte_i       (data_byte_i),
    .last_byte_i       (last_byte_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .es_id_o           (es_id_o),
    .stream_priority_o (stream_priority_o),
    .object_type_o     (object_type_o),
    .stream_kind_o     (stream_kind_o),
    .buffer_size_o     (buffer_size_o),
    .max_bitrate_o     (max_bitrate_o),
    .avg_bitrate_o     (avg_bitrate_o),
    .extra_start_o     (extra_start_o),
    .extra_length_o    (extra_length_o)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // run limit
  initial begin
    #5ms;
    $display("tb_es_descriptor_parser NOT OK");
    $finish;
  end

  // parser back to the first tag, all fields cleared
  function automatic void clear_parser();
    parse_ph  = esdp_pkg::PH_TAG1;
    field_cnt = '0;
    len_acc   = '0;
    tag_q     = '0;
    byte_pos  = '0;
    id_q      = '0;
    prio_q    = '0;
    obj_q     = '0;
    kind_q    = '0;
    buf_q     = '0;
    maxr_q    = '0;
    avgr_q    = '0;
  endfunction

  // one 7-bit length group; true once the length is complete
  function automatic bit len_group(input logic [7:0] b);
    len_acc   = {len_acc[esdp_pkg::LenWidth-8:0], b[6:0]};
    field_cnt = field_cnt + 1'b1;
    if (!b[7] || field_cnt >= esdp_pkg::MaxLenBytes) begin
      field_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic esdp_pkg::result_t snapshot(input esdp_pkg::status_e st,
                                                 input bit with_pos);
    esdp_pkg::result_t r;
    r.status          = st;
    r.es_id           = id_q;
    r.stream_priority = prio_q;
    r.object_type     = obj_q;
    r.stream_kind     = kind_q;
    r.buffer_size     = buf_q;
    r.max_bitrate     = maxr_q;
    r.avg_bitrate     = avgr_q;
    r.extra_start     = with_pos ?
                        base_q + {{(esdp_pkg::BaseWidth-esdp_pkg::OffWidth){1'b0}}, byte_pos}
                        : '0;
    r.extra_length    = with_pos ? len_acc : '0;
    return r;
  endfunction

  // advance the mirrored parser by one byte, giving the result it decides
  task automatic parse_byte(input logic [7:0] b, input logic lst,
                            output bit hit, output esdp_pkg::result_t r);
    hit      = 1'b0;
    r        = '0;
    byte_pos = byte_pos + 1'b1;
    case (parse_ph)
      esdp_pkg::PH_TAG1: begin
        tag_q = b; len_acc = '0; field_cnt = '0; parse_ph = esdp_pkg::PH_LEN1;
      end
      esdp_pkg::PH_LEN1: if (len_group(b)) parse_ph = esdp_pkg::PH_ID;
      esdp_pkg::PH_ID: begin
        id_q      = {id_q[7:0], b};
        field_cnt = field_cnt + 1'b1;
        if (field_cnt >= 2) begin
          field_cnt = '0;
          parse_ph  = (tag_q == esdp_pkg::TagEsDesc) ? esdp_pkg::PH_PRIO : esdp_pkg::PH_TAG2;
        end
      end
      esdp_pkg::PH_PRIO: begin
        prio_q = b; parse_ph = esdp_pkg::PH_TAG2;
      end
      esdp_pkg::PH_TAG2: begin
        tag_q = b; len_acc = '0; field_cnt = '0; parse_ph = esdp_pkg::PH_LEN2;
      end
      esdp_pkg::PH_LEN2: if (len_group(b)) begin
        if (tag_q == esdp_pkg::TagDecConfig) parse_ph = esdp_pkg::PH_OBJ;
        else begin
          r = snapshot(esdp_pkg::ST_NOT_FOUND, 1'b0); hit = 1'b1;
        end
      end
      esdp_pkg::PH_OBJ: begin
        obj_q = b; parse_ph = esdp_pkg::PH_STYPE;
      end
      esdp_pkg::PH_STYPE: begin
        kind_q = b; parse_ph = esdp_pkg::PH_BUF;
      end
      esdp_pkg::PH_BUF: begin
        buf_q     = {buf_q[15:0], b};
        field_cnt = field_cnt + 1'b1;
        if (field_cnt >= 3) begin
          field_cnt = '0; parse_ph = esdp_pkg::PH_MAXR;
        end
      end
      esdp_pkg::PH_MAXR: begin
        maxr_q    = {maxr_q[23:0], b};
        field_cnt = field_cnt + 1'b1;
        if (field_cnt >= 4) begin
          field_cnt = '0; parse_ph = esdp_pkg::PH_AVGR;
        end
      end
      esdp_pkg::PH_AVGR: begin
        avgr_q    = {avgr_q[23:0], b};
        field_cnt = field_cnt + 1'b1;
        if (field_cnt >= 4) begin
          field_cnt = '0; parse_ph = esdp_pkg::PH_TAG3;
        end
      end
      esdp_pkg::PH_TAG3: begin
        tag_q = b; len_acc = '0; field_cnt = '0; parse_ph = esdp_pkg::PH_LEN3;
      end
      esdp_pkg::PH_LEN3: if (len_group(b)) begin
        if (tag_q == esdp_pkg::TagSlConfig) parse_ph = esdp_pkg::PH_UNK;
        else begin
          r   = snapshot((tag_q == esdp_pkg::TagDecSpecific) ? esdp_pkg::ST_OK
                                                             : esdp_pkg::ST_NOT_FOUND,
                         tag_q == esdp_pkg::TagDecSpecific);
          hit = 1'b1;
        end
      end
      esdp_pkg::PH_UNK: parse_ph = esdp_pkg::PH_TAG4;
      esdp_pkg::PH_TAG4: begin
        tag_q = b; len_acc = '0; field_cnt = '0; parse_ph = esdp_pkg::PH_LEN4;
      end
      esdp_pkg::PH_LEN4: if (len_group(b)) begin
        r   = snapshot((tag_q == esdp_pkg::TagDecSpecific) ? esdp_pkg::ST_OK
                                                           : esdp_pkg::ST_NOT_FOUND,
                       tag_q == esdp_pkg::TagDecSpecific);
        hit = 1'b1;
      end
      default: ;
    endcase
    if (hit) parse_ph = esdp_pkg::PH_SKIP;
    // end of box: undecided means truncated, then restart
    if (lst) begin
      if (parse_ph != esdp_pkg::PH_SKIP) begin
        r   = snapshot(esdp_pkg::ST_TRUNCATED, 1'b0);
        hit = 1'b1;
      end
      clear_parser();
    end
  endtask

  // one byte transfer with random idle gaps ahead of it
  task automatic send_byte(input logic [7:0] b, input logic lst,
                           input bit typed, input esdp_pkg::result_t want);
    bit                hit;
    esdp_pkg::result_t r;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= lst;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    parse_byte(b, lst, hit, r);
    if (typed) pending_results.push_back(want);
    else if (hit) pending_results.push_back(r);
  endtask

  // hold the sender until every expected result has come out
  task automatic wait_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // payload_base write while the parser is idle
  task automatic write_base(input logic [esdp_pkg::BaseWidth-1:0] v);
    wait_results();
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    base_q       = v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // descriptor length in one to four groups, sometimes overlong
  task automatic push_len();
    int unsigned   n_grp;
    logic [27:0]   v;
    bit            over;
    n_grp = $urandom_range(1, 4);
    case ($urandom_range(0, 4))
      0:       v = '0;
      1:       v = 28'hFFF_FFFF;
      2:       v = 28'($urandom_range(0, 300));
      default: v = 28'($urandom);
    endcase
    over = (n_grp == 4) && ($urandom_range(0, 7) == 0);
    for (int i = n_grp - 1; i >= 0; i--)
      box_bytes.push_back({(i > 0) || over, v[7*i +: 7]});
  endtask

  // one box: mostly well-formed descriptors, some cut short, some noise
  task automatic build_box();
    logic [7:0]  t;
    int unsigned pick;
    box_bytes.delete();
    if ($urandom_range(0, 99) < 6) begin
      repeat ($urandom_range(1, 24)) box_bytes.push_back(rand_byte());
      return;
    end
    t = ($urandom_range(0, 9) < 6) ? esdp_pkg::TagEsDesc : rand_byte();
    box_bytes.push_back(t);
    push_len();
    box_bytes.push_back(rand_byte());
    box_bytes.push_back(rand_byte());
    if (t == esdp_pkg::TagEsDesc) box_bytes.push_back(rand_byte());
    box_bytes.push_back(($urandom_range(0, 99) < 88) ? esdp_pkg::TagDecConfig : rand_byte());
    push_len();
    repeat (13) box_bytes.push_back(rand_byte());
    pick = $urandom_range(0, 99);
    t    = (pick < 45) ? esdp_pkg::TagDecSpecific :
           (pick < 80) ? esdp_pkg::TagSlConfig : rand_byte();
    box_bytes.push_back(t);
    push_len();
    if (t == esdp_pkg::TagSlConfig) begin
      box_bytes.push_back(rand_byte());
      box_bytes.push_back(($urandom_range(0, 3) != 0) ? esdp_pkg::TagDecSpecific : rand_byte());
      push_len();
    end
    repeat ($urandom_range(0, 4)) box_bytes.push_back(rand_byte());
    // early end of box
    if ($urandom_range(0, 99) < 15)
      while (box_bytes.size() > $urandom_range(1, box_bytes.size())) void'(box_bytes.pop_back());
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
    n_errors++;
  endtask

  // receiver stall
  always @(posedge clk_i) out_stall_i <= ($urandom_range(0, 99) < stall_pct);

  // result transfer check against the oldest expectation
  always @(posedge clk_i) begin
    esdp_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with none pending", 64'(status_o), '0);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status)
          flag_mismatch("status", 64'(status_o), 64'(want.status));
        if (es_id_o !== want.es_id)
          flag_mismatch("es_id", 64'(es_id_o), 64'(want.es_id));
        if (stream_priority_o !== want.stream_priority)
          flag_mismatch("stream_priority", 64'(stream_priority_o),
                        64'(want.stream_priority));
        if (object_type_o !== want.object_type)
          flag_mismatch("object_type", 64'(object_type_o), 64'(want.object_type));
        if (stream_kind_o !== want.stream_kind)
          flag_mismatch("stream_kind", 64'(stream_kind_o), 64'(want.stream_kind));
        if (buffer_size_o !== want.buffer_size)
          flag_mismatch("buffer_size", 64'(buffer_size_o), 64'(want.buffer_size));
        if (max_bitrate_o !== want.max_bitrate)
          flag_mismatch("max_bitrate", 64'(max_bitrate_o), 64'(want.max_bitrate));
        if (avg_bitrate_o !== want.avg_bitrate)
          flag_mismatch("avg_bitrate", 64'(avg_bitrate_o), 64'(want.avg_bitrate));
        if (extra_start_o !== want.extra_start)
          flag_mismatch("extra_start", 64'(extra_start_o), 64'(want.extra_start));
        if (extra_length_o !== want.extra_length)
          flag_mismatch("extra_length", 64'(extra_length_o), 64'(want.extra_length));
      end
    end
  end

  // stimulus
  initial begin
    int unsigned                    phase_idle  [NumPhases] = '{0, 78, 0, 27, 0, 27};
    int unsigned                    phase_stall [NumPhases] = '{0, 0, 78, 27, 0, 27};
    logic [esdp_pkg::BaseWidth-1:0] phase_base  [NumPhases];
    int unsigned                    sent;
    int unsigned                    n_box;
    esdp_pkg::result_t              want;

    base_q = '0;
    clear_parser();
    phase_base = '{48'h0, 48'hFFFF_FFFF_FFFF, 48'({$urandom, $urandom}),
                   48'hFFFF_FFFF_FF00, 48'({$urandom, $urandom}), 48'h0};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (DirectedRows[i]) begin
      want                 = '0;
      want.status          = DirectedRows[i].st;
      want.es_id           = DirectedRows[i].id;
      want.stream_priority = DirectedRows[i].prio;
      want.object_type     = DirectedRows[i].obj;
      send_byte(DirectedRows[i].b, DirectedRows[i].lst, DirectedRows[i].typed, want);
    end

    // random boxes, one idling mode and base position per phase
    for (int p = 0; p < NumPhases; p++) begin
      write_base(phase_base[p]);
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      sent      = 0;
      n_box     = 0;
      while (sent < PhaseBytes) begin
        build_box();
        foreach (box_bytes[k])
          send_byte(box_bytes[k], k == box_bytes.size() - 1, 1'b0, '0);
        sent += box_bytes.size();
        n_box++;
        if (n_box % 8 == 0) wait_results();
      end
    end

    wait_results();
    repeat (10) @(posedge clk_i);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("tb_es_descriptor_parser OK");
    end else begin
      $display("tb_es_descriptor_parser NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/esdp_pkg.sv
hdl/esdp_in_reg.sv
hdl/esdp_parser.sv
hdl/esdp_out_reg.sv
hdl/es_descriptor_parser.sv
verif/tb_es_descriptor_parser.sv
